// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the wavefolder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked outside reset.
`define WF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wavefolder assertion failed");
// Property checked at every edge, reset included.
`define WF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("wavefolder assertion failed");
`else
`define WF_ASSERT(label, clk, rst, prop)
`define WF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- hw/rtl/wf_pkg.sv -----
// ----------------------------------------------------------------------------
// Wavefolder package
// Widths, fixed-point constants and the bus that runs along the fold cells.
// ----------------------------------------------------------------------------
package wf_pkg;

  localparam int NCELLS   = 5;
  localparam int OTERM_W  = 48;   // offset * 0.6, Q47
  localparam int GAIN_W   = 35;   // fold gain, unsigned Q32
  localparam int Q_W      = 51;   // drive before rounding, Q47
  localparam int DRIVE_W  = 35;   // drive, signed Q31
  localparam int MAG_W    = 34;   // |drive|
  localparam int ACC_W    = 58;   // segment sum, Q47
  localparam int SLOPE_W  = 21;
  localparam int SGNK_W   = 23;
  localparam int U_W      = 22;   // biased quotient input for the divide by three
  localparam int RCP_W    = 23;
  localparam int OUT_W    = 20;

  localparam logic [GAIN_W-1:0]  FOLD_K  = 35'd353894;        // 5.4 in Q16
  localparam logic [GAIN_W-1:0]  GAIN_C  = 35'd2577006592;    // 0.6 in Q32
  localparam logic [31:0]        OFF_K   = 32'd2577006592;    // 0.6 in Q32
  localparam logic signed [Q_W-1:0] DRIVE_RND = 51'sd32768;
  localparam logic signed [ACC_W-1:0] OUT_RND = 58'sd6442450944;  // 1.5 * 2^32
  localparam logic signed [25:0] T_LIMIT  = 26'sd1572864;     // 3 * 2^19
  localparam logic [RCP_W-1:0]   RECIP3   = 23'd5592406;      // ceil(2^24 / 3)
  localparam logic [OUT_W-1:0]   Q_BIAS   = 20'h80000;
  localparam logic [OUT_W-1:0]   OUT_MAX  = 20'h7FFFF;
  localparam logic [OUT_W-1:0]   OUT_MIN  = 20'h80000;

  localparam logic [MAG_W-1:0] THR [NCELLS] = '{
    34'd1288490189, 34'd3865470566, 34'd6429566042, 34'd8761733284, 34'd11725260718
  };
  localparam logic signed [SLOPE_W-1:0] SLOPE [NCELLS] = '{
    -21'sd655334, 21'sd664186, -21'sd685924, 21'sd636999, -21'sd397463
  };
  localparam logic signed [SGNK_W-1:0] SGNK [NCELLS] = '{
    23'sd393216, -23'sd1195604, 23'sd2053586, -23'sd2599231, 23'sd2170102
  };

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic [MAG_W-1:0]          mag;
    logic                      neg;   // raw sample below zero
    logic signed [ACC_W-1:0]   acc;
  } cell_bus_t;

endpackage

// ----- hw/rtl/wf_drive.sv -----
// ----------------------------------------------------------------------------
// Wavefolder drive unit
// Forms the drive offset*0.6 + (fold*5.4 + 0.6)*sample in three stages.
// ----------------------------------------------------------------------------
module wf_drive (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  sample,
  input  logic [15:0]         fold_amount,
  input  logic signed [15:0]  offset,
  output logic                out_valid,
  input  logic                out_ready,
  output wf_pkg::cell_bus_t   out_bus
);
  import wf_pkg::*;

  logic va, vb;
  logic ra, rb, rc;

  logic [GAIN_W-1:0]         gain;
  logic signed [OTERM_W-1:0] oterm;
  logic signed [15:0]        sample_a, sample_b;
  logic signed [Q_W-1:0]     q47;

  logic [GAIN_W-1:0]         gain_next;
  logic signed [OTERM_W-1:0] oterm_next;
  logic signed [Q_W-1:0]     q47_next;
  logic signed [Q_W-1:0]     rnd;
  logic signed [DRIVE_W-1:0] drive_c, neg_drive;
  cell_bus_t                 bus_next;

  assign rc       = !out_valid || out_ready;
  assign rb       = !vb || rc;
  assign ra       = !va || rb;
  assign in_ready = ra;

  always_comb begin
    gain_next  = GAIN_W'(fold_amount) * FOLD_K + GAIN_C;
    oterm_next = OTERM_W'(offset) * $signed(OTERM_W'(OFF_K));
    q47_next   = Q_W'(oterm) + $signed(Q_W'(gain)) * Q_W'(sample_a);
    rnd        = q47 + DRIVE_RND;
    drive_c    = rnd[Q_W-1:16];
    neg_drive  = -drive_c;
    bus_next.drive = drive_c;
    bus_next.mag   = drive_c[DRIVE_W-1] ? neg_drive[MAG_W-1:0] : drive_c[MAG_W-1:0];
    bus_next.neg   = sample_b[15];
    // 5 * drive in Q47 is drive * 2^16 + drive * 2^18.
    bus_next.acc   = (ACC_W'(drive_c) <<< 16) + (ACC_W'(drive_c) <<< 18);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ra) va <= in_valid;
      if (rb) vb <= va;
      if (rc) out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (ra && in_valid) begin
      gain     <= gain_next;
      oterm    <= oterm_next;
      sample_a <= sample;
    end
    if (rb && va) begin
      q47      <= q47_next;
      sample_b <= sample_a;
    end
    if (rc && vb) begin
      out_bus <= bus_next;
    end
  end

endmodule

// ----- hw/rtl/wf_cell.sv -----
// ----------------------------------------------------------------------------
// Wavefolder fold cell
// One folding stage: adds its linear segment when the drive passes its threshold.
// ----------------------------------------------------------------------------
module wf_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [wf_pkg::MAG_W-1:0]           thr,
  input  logic signed [wf_pkg::SLOPE_W-1:0]  slope,
  input  logic signed [wf_pkg::SGNK_W-1:0]   sgnk,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  wf_pkg::cell_bus_t                  in_bus,
  output logic                               out_valid,
  input  logic                               out_ready,
  output wf_pkg::cell_bus_t                  out_bus
);
  import wf_pkg::*;

  logic                    active;
  logic signed [ACC_W-1:0] prod, sterm, seg;
  cell_bus_t               bus_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    active = in_bus.mag >= thr;
    prod   = ACC_W'(in_bus.drive) * ACC_W'(slope);
    sterm  = ACC_W'(sgnk) <<< 31;
    seg    = prod + (in_bus.neg ? -sterm : sterm);
    bus_next     = in_bus;
    bus_next.acc = in_bus.acc + (active ? seg : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_bus <= bus_next;
    end
  end

endmodule

// ----- hw/rtl/wf_scale.sv -----
// ----------------------------------------------------------------------------
// Wavefolder output scaler
// Divides the segment sum by three, rounds to Q4.15 and saturates.
// ----------------------------------------------------------------------------
module wf_scale (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  wf_pkg::cell_bus_t         in_bus,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [wf_pkg::OUT_W-1:0]  folded
);
  import wf_pkg::*;

  logic                 va;
  logic                 ra, rb;
  logic [U_W-1:0]       u;
  logic                 hi, lo;

  logic signed [ACC_W-1:0] sum;
  logic signed [25:0]      t, tb;
  logic [U_W+RCP_W-1:0]    prod;
  logic [OUT_W-1:0]        folded_next;

  assign rb       = !out_valid || out_ready;
  assign ra       = !va || rb;
  assign in_ready = ra;

  always_comb begin
    sum  = in_bus.acc + OUT_RND;
    t    = sum[ACC_W-1:32];
    tb   = t + T_LIMIT;
    prod = (U_W+RCP_W)'(u) * (U_W+RCP_W)'(RECIP3);
    if (hi) begin
      folded_next = OUT_MAX;
    end else if (lo) begin
      folded_next = OUT_MIN;
    end else begin
      folded_next = prod[OUT_W+23:24] - Q_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ra) va <= in_valid;
      if (rb) out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ra && in_valid) begin
      u  <= tb[U_W-1:0];
      hi <= t >= T_LIMIT;
      lo <= t < -T_LIMIT;
    end
    if (rb && va) begin
      folded <= folded_next;
    end
  end

endmodule

// ----- hw/rtl/five_stage_wavefolder_top.sv -----
// ----------------------------------------------------------------------------
// Five-stage wavefolder
// Streaming Q1.15 wavefolder with per-item fold amount and offset.
// ----------------------------------------------------------------------------
// Pipeline: 10 register stages (3 drive, 5 fold, 2 scale); the result is valid
// once its item has passed through all of them, and is held until it is taken.
// Throughput: one item per cycle unless the output stalls; every stage is a register
// with its own valid bit. A stalled output fills empty stages first, so input is
// taken until all are full. Reset clears every valid bit; data registers are not reset.
module five_stage_wavefolder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // sample [15:0], fold_amount [31:16], offset [47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // folded [19:0], zero [23:20]
);
  import wf_pkg::*;

  `include "assert_macros.svh"

  // Handshake and data along the chain: index 0 is the drive unit output,
  // index NCELLS feeds the output scaler.
  logic      cv [NCELLS+1];
  logic      cr [NCELLS+1];
  cell_bus_t cb [NCELLS+1];

  logic [OUT_W-1:0] folded;

  // The drive unit forms the Q31 drive, its magnitude and the sign of the
  // raw sample, and seeds the accumulator with 5 * drive.
  wf_drive u_drive (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .sample      ($signed(s_tdata[15:0])),
    .fold_amount (s_tdata[31:16]),
    .offset      ($signed(s_tdata[47:32])),
    .out_valid   (cv[0]),
    .out_ready   (cr[0]),
    .out_bus     (cb[0])
  );

  // Each fold cell compares |drive| with its own threshold and adds its
  // segment; thresholds rise along the chain.
  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    wf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .thr       (THR[k]),
      .slope     (SLOPE[k]),
      .sgnk      (SGNK[k]),
      .in_valid  (cv[k]),
      .in_ready  (cr[k]),
      .in_bus    (cb[k]),
      .out_valid (cv[k+1]),
      .out_ready (cr[k+1]),
      .out_bus   (cb[k+1])
    );
  end

  // The scaler divides by three with a reciprocal multiply, rounds to
  // Q4.15 and saturates; its last register is the output register.
  wf_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cv[NCELLS]),
    .in_ready  (cr[NCELLS]),
    .in_bus    (cb[NCELLS]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .folded    (folded)
  );

  assign m_tdata = {4'b0000, folded};

  // Input is refused only when every stage holds an item and the output stalls.
  `WF_ASSERT(a_full_stall, clk, rst, !s_tready |-> (m_tvalid && !m_tready && cv[NCELLS]))
  // Reset empties the whole chain.
  `WF_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!m_tvalid && s_tready && !cv[0]))
  // The drive unit, when it holds an item and the first cell is empty, must hand it on.
  `WF_ASSERT(a_cell_moves, clk, rst, (cv[0] && !cv[1]) |-> cr[0])

endmodule
